/* sv/c8core_pkg.sv */
package c8core_pkg;

    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int STACK_DEPTH_DEF  = 16;
    localparam int SCREEN_PIXELS    = 2048;
    localparam int FB_BYTES         = SCREEN_PIXELS / 8;
    localparam int FB_AW            = $clog2(FB_BYTES);
    localparam int FONT_BYTES       = 80;

    localparam logic [11:0] PC_START = 12'h200;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_SNE  = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LD   = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_DRW  = 4'hD;

    localparam logic [3:0] FLAG_REG = 4'hF;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_EXEC = 2'd1,
        CMD_FBRD = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_INIT,
        OP_ACCEPT,
        OP_LOAD,
        OP_FB_RD,
        OP_FETCH_HI,
        OP_FETCH_LO,
        OP_FETCH_END,
        OP_RD_X,
        OP_RD_Y,
        OP_EXEC,
        OP_DRAW_MEM,
        OP_DRAW_RDA,
        OP_DRAW_RDB,
        OP_DRAW_WRA,
        OP_DRAW_WRB,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_FBRD,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_FETCH_END,
        ST_RD_X,
        ST_RD_Y,
        ST_EXEC,
        ST_DRAW_MEM,
        ST_DRAW_RDA,
        ST_DRAW_RDB,
        ST_DRAW_WRA,
        ST_DRAW_WRB,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic in_valid;
        logic init_last;
        cmd_t cmd;
        logic draw;
        logic n_zero;
        logic draw_last;
        logic out_free;
    } dp_stat_t;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

/* sv/c8core_req_if.sv */
interface c8core_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  load_byte;

    modport source (output valid, output command, output address, output load_byte,
                    input ready);
    modport sink (input valid, input command, input address, input load_byte,
                  output ready);
endinterface

/* sv/c8core_res_if.sv */
interface c8core_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_byte;
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic        status;
    logic        screen_changed;

    modport source (output valid, output pixel_byte, output program_counter,
                    output executed_opcode, output status, output screen_changed,
                    input ready);
    modport sink (input valid, input pixel_byte, input program_counter,
                  input executed_opcode, input status, input screen_changed,
                  output ready);
endinterface

/* sv/c8core_ram.sv */
module c8core_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

/* sv/c8core_ctrl.sv */
module c8core_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  c8core_pkg::dp_stat_t stat,
    output c8core_pkg::dp_op_t  op
);

    c8core_pkg::state_t state_reg;
    c8core_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8core_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            c8core_pkg::ST_INIT:
            begin
                if (stat.init_last)
                begin
                    state_next = c8core_pkg::ST_IDLE;
                end
            end
            c8core_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = c8core_pkg::ST_DISPATCH;
                end
            end
            c8core_pkg::ST_DISPATCH:
            begin
                unique case (stat.cmd)
                    c8core_pkg::CMD_LOAD: state_next = c8core_pkg::ST_LOAD;
                    c8core_pkg::CMD_EXEC: state_next = c8core_pkg::ST_FETCH_HI;
                    c8core_pkg::CMD_FBRD: state_next = c8core_pkg::ST_FBRD;
                    c8core_pkg::CMD_NONE: state_next = c8core_pkg::ST_FINISH;
                endcase
            end
            c8core_pkg::ST_LOAD:      state_next = c8core_pkg::ST_FINISH;
            c8core_pkg::ST_FBRD:      state_next = c8core_pkg::ST_FINISH;
            c8core_pkg::ST_FETCH_HI:  state_next = c8core_pkg::ST_FETCH_LO;
            c8core_pkg::ST_FETCH_LO:  state_next = c8core_pkg::ST_FETCH_END;
            c8core_pkg::ST_FETCH_END: state_next = c8core_pkg::ST_RD_X;
            c8core_pkg::ST_RD_X:      state_next = c8core_pkg::ST_RD_Y;
            c8core_pkg::ST_RD_Y:      state_next = c8core_pkg::ST_EXEC;
            c8core_pkg::ST_EXEC:
            begin
                if (stat.draw && !stat.n_zero)
                begin
                    state_next = c8core_pkg::ST_DRAW_MEM;
                end
                else
                begin
                    state_next = c8core_pkg::ST_FINISH;
                end
            end
            c8core_pkg::ST_DRAW_MEM:  state_next = c8core_pkg::ST_DRAW_RDA;
            c8core_pkg::ST_DRAW_RDA:  state_next = c8core_pkg::ST_DRAW_RDB;
            c8core_pkg::ST_DRAW_RDB:  state_next = c8core_pkg::ST_DRAW_WRA;
            c8core_pkg::ST_DRAW_WRA:  state_next = c8core_pkg::ST_DRAW_WRB;
            c8core_pkg::ST_DRAW_WRB:
            begin
                if (stat.draw_last)
                begin
                    state_next = c8core_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = c8core_pkg::ST_DRAW_MEM;
                end
            end
            c8core_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = c8core_pkg::ST_IDLE;
                end
            end
            default: state_next = c8core_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        op = c8core_pkg::OP_IDLE;
        unique case (state_reg)
            c8core_pkg::ST_INIT:      op = c8core_pkg::OP_INIT;
            c8core_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    op = c8core_pkg::OP_ACCEPT;
                end
            end
            c8core_pkg::ST_DISPATCH:  op = c8core_pkg::OP_IDLE;
            c8core_pkg::ST_LOAD:      op = c8core_pkg::OP_LOAD;
            c8core_pkg::ST_FBRD:      op = c8core_pkg::OP_FB_RD;
            c8core_pkg::ST_FETCH_HI:  op = c8core_pkg::OP_FETCH_HI;
            c8core_pkg::ST_FETCH_LO:  op = c8core_pkg::OP_FETCH_LO;
            c8core_pkg::ST_FETCH_END: op = c8core_pkg::OP_FETCH_END;
            c8core_pkg::ST_RD_X:      op = c8core_pkg::OP_RD_X;
            c8core_pkg::ST_RD_Y:      op = c8core_pkg::OP_RD_Y;
            c8core_pkg::ST_EXEC:      op = c8core_pkg::OP_EXEC;
            c8core_pkg::ST_DRAW_MEM:  op = c8core_pkg::OP_DRAW_MEM;
            c8core_pkg::ST_DRAW_RDA:  op = c8core_pkg::OP_DRAW_RDA;
            c8core_pkg::ST_DRAW_RDB:  op = c8core_pkg::OP_DRAW_RDB;
            c8core_pkg::ST_DRAW_WRA:  op = c8core_pkg::OP_DRAW_WRA;
            c8core_pkg::ST_DRAW_WRB:  op = c8core_pkg::OP_DRAW_WRB;
            c8core_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    op = c8core_pkg::OP_FINISH;
                end
            end
            default:                  op = c8core_pkg::OP_IDLE;
        endcase
    end

endmodule

/* sv/c8core_dp.sv */
module c8core_dp #(
    parameter int MEMORY_BYTES = c8core_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = c8core_pkg::STACK_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  c8core_pkg::dp_op_t   op,
    output c8core_pkg::dp_stat_t stat,
    c8core_req_if.sink           request,
    c8core_res_if.source         result
);

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int FW = c8core_pkg::FB_AW;

    // Reduce a 13-bit address modulo the memory size by conditional subtraction.
    function automatic logic [AW-1:0] mem_wrap(input logic [12:0] a);
        logic [12:0] v;
        v = a;
        for (int i = 0; i < 4; i++)
        begin
            if (v >= 13'(MEMORY_BYTES))
            begin
                v = v - 13'(MEMORY_BYTES);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [1:0]    cmd_reg;
    logic [11:0]   addr_reg;
    logic [7:0]    lb_reg;
    logic [11:0]   pc_reg;
    logic [11:0]   idx_reg;
    logic [SW-1:0] sp_reg;
    logic [7:0]    v_reg   [16];
    logic [11:0]   stk_reg [STACK_DEPTH];
    logic          fbv_reg [c8core_pkg::FB_BYTES];
    logic [15:0]   op_reg;
    logic [7:0]    vx_reg;
    logic [7:0]    vy_reg;
    logic [7:0]    spr_reg;
    logic [7:0]    fba_reg;
    logic [7:0]    fbb_reg;
    logic [3:0]    row_reg;
    logic          hit_reg;
    logic          st_reg;
    logic          chg_reg;
    logic [AW-1:0] init_reg;
    logic          fbq_reg;
    logic          ov_reg;
    logic [7:0]    pix_o_reg;
    logic [11:0]   pc_o_reg;
    logic [15:0]   op_o_reg;
    logic          st_o_reg;
    logic          chg_o_reg;

    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_wd;
    logic [7:0]    mem_rd;
    logic [FW-1:0] fb_addr;
    logic          fb_we;
    logic          fb_re;
    logic [7:0]    fb_wd;
    logic [7:0]    fb_rd;
    logic [7:0]    fb_data;

    logic [3:0]    grp;
    logic [3:0]    rx;
    logic [3:0]    ry;
    logic [3:0]    rn;
    logic [7:0]    kk;
    logic [11:0]   nnn;
    logic [SW-1:0] sp_dec;
    logic [SW-1:0] sp_inc;
    logic [4:0]    row_y;
    logic [2:0]    col_a;
    logic [15:0]   mask_ab;
    logic [FW-1:0] fb_a;
    logic [FW-1:0] fb_b;
    logic          hit_fin;

    assign grp = op_reg[15:12];
    assign rx  = op_reg[11:8];
    assign ry  = op_reg[7:4];
    assign rn  = op_reg[3:0];
    assign kk  = op_reg[7:0];
    assign nnn = op_reg[11:0];

    assign sp_dec = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;

    // Sprite row lands across two frame bytes on the same screen row.
    assign row_y   = vy_reg[4:0] + {1'b0, row_reg};
    assign col_a   = vx_reg[5:3];
    assign mask_ab = {spr_reg, 8'h00} >> vx_reg[2:0];
    assign fb_a    = {row_y, col_a};
    assign fb_b    = {row_y, col_a + 3'd1};
    assign fb_data = fbq_reg ? fb_rd : 8'h00;
    assign hit_fin = hit_reg | (|(fbb_reg & mask_ab[7:0]));

    assign stat.in_valid  = request.valid;
    assign stat.init_last = (init_reg == AW'(MEMORY_BYTES - 1));
    assign stat.cmd       = c8core_pkg::cmd_t'(cmd_reg);
    assign stat.draw      = (grp == c8core_pkg::GRP_DRW);
    assign stat.n_zero    = (rn == 4'd0);
    assign stat.draw_last = (row_reg == rn - 4'd1);
    assign stat.out_free  = !ov_reg || result.ready;

    assign request.ready          = (op == c8core_pkg::OP_ACCEPT);
    assign result.valid           = ov_reg;
    assign result.pixel_byte      = pix_o_reg;
    assign result.program_counter = pc_o_reg;
    assign result.executed_opcode = op_o_reg;
    assign result.status          = st_o_reg;
    assign result.screen_changed  = chg_o_reg;

    always_comb
    begin
        mem_addr = mem_wrap({1'b0, pc_reg});
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_wd   = lb_reg;
        fb_addr  = fb_a;
        fb_we    = 1'b0;
        fb_re    = 1'b0;
        fb_wd    = fba_reg ^ mask_ab[15:8];
        unique case (op)
            c8core_pkg::OP_INIT:
            begin
                mem_addr = init_reg;
                mem_we   = 1'b1;
                mem_wd   = (init_reg < AW'(c8core_pkg::FONT_BYTES))
                           ? c8core_pkg::FONT[init_reg[6:0]] : 8'h00;
            end
            c8core_pkg::OP_LOAD:
            begin
                mem_addr = mem_wrap({1'b0, addr_reg});
                mem_we   = 1'b1;
            end
            c8core_pkg::OP_FETCH_HI:
            begin
                mem_re = 1'b1;
            end
            c8core_pkg::OP_FETCH_LO:
            begin
                mem_addr = mem_wrap({1'b0, pc_reg} + 13'd1);
                mem_re   = 1'b1;
            end
            c8core_pkg::OP_DRAW_MEM:
            begin
                mem_addr = mem_wrap({1'b0, idx_reg} + {9'd0, row_reg});
                mem_re   = 1'b1;
            end
            c8core_pkg::OP_FB_RD:
            begin
                fb_addr = addr_reg[FW-1:0];
                fb_re   = 1'b1;
            end
            c8core_pkg::OP_DRAW_RDA:
            begin
                fb_re = 1'b1;
            end
            c8core_pkg::OP_DRAW_RDB:
            begin
                fb_addr = fb_b;
                fb_re   = 1'b1;
            end
            c8core_pkg::OP_DRAW_WRA:
            begin
                fb_we = 1'b1;
            end
            c8core_pkg::OP_DRAW_WRB:
            begin
                fb_addr = fb_b;
                fb_we   = 1'b1;
                fb_wd   = fbb_reg ^ mask_ab[7:0];
            end
            default:
            begin
            end
        endcase
    end

    c8core_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_BYTES)
    ) u_main_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wd),
        .rdata (mem_rd)
    );

    c8core_ram #(
        .WIDTH (8),
        .DEPTH (c8core_pkg::FB_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (fb_we),
        .re    (fb_re),
        .addr  (fb_addr),
        .wdata (fb_wd),
        .rdata (fb_rd)
    );

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (op)
            c8core_pkg::OP_ACCEPT:
            begin
                cmd_reg  <= request.command;
                addr_reg <= request.address;
                lb_reg   <= request.load_byte;
            end
            c8core_pkg::OP_FETCH_LO:  op_reg[15:8] <= mem_rd;
            c8core_pkg::OP_FETCH_END: op_reg[7:0]  <= mem_rd;
            c8core_pkg::OP_RD_X:      vx_reg <= v_reg[rx];
            c8core_pkg::OP_RD_Y:      vy_reg <= v_reg[ry];
            c8core_pkg::OP_DRAW_RDA:  spr_reg <= mem_rd;
            c8core_pkg::OP_DRAW_RDB:  fba_reg <= fb_data;
            c8core_pkg::OP_DRAW_WRA:  fbb_reg <= fb_data;
            c8core_pkg::OP_FINISH:
            begin
                pix_o_reg <= (cmd_reg == c8core_pkg::CMD_FBRD) ? fb_data : 8'h00;
                pc_o_reg  <= pc_reg;
                op_o_reg  <= (cmd_reg == c8core_pkg::CMD_EXEC) ? op_reg : 16'h0000;
                st_o_reg  <= st_reg;
                chg_o_reg <= chg_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= c8core_pkg::PC_START;
            idx_reg  <= '0;
            sp_reg   <= '0;
            row_reg  <= '0;
            hit_reg  <= 1'b0;
            st_reg   <= 1'b0;
            chg_reg  <= 1'b0;
            init_reg <= '0;
            fbq_reg  <= 1'b0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= '0;
            end
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stk_reg[i] <= '0;
            end
            for (int i = 0; i < c8core_pkg::FB_BYTES; i++)
            begin
                fbv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (fb_re)
            begin
                fbq_reg <= fbv_reg[fb_addr];
            end
            if (fb_we)
            begin
                fbv_reg[fb_addr] <= 1'b1;
            end
            if (op == c8core_pkg::OP_FINISH)
            begin
                ov_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (op)
                c8core_pkg::OP_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                end
                c8core_pkg::OP_ACCEPT:
                begin
                    st_reg  <= 1'b0;
                    chg_reg <= 1'b0;
                end
                c8core_pkg::OP_EXEC:
                begin
                    case (grp)
                        c8core_pkg::GRP_SYS:
                        begin
                            if (op_reg == c8core_pkg::OPC_CLS)
                            begin
                                for (int i = 0; i < c8core_pkg::FB_BYTES; i++)
                                begin
                                    fbv_reg[i] <= 1'b0;
                                end
                                chg_reg <= 1'b1;
                                pc_reg  <= pc_reg + 12'd2;
                            end
                            else if (op_reg == c8core_pkg::OPC_RET)
                            begin
                                sp_reg <= sp_dec;
                                pc_reg <= stk_reg[sp_dec] + 12'd2;
                            end
                            else
                            begin
                                st_reg <= 1'b1;
                            end
                        end
                        c8core_pkg::GRP_JP:
                        begin
                            pc_reg <= nnn;
                        end
                        c8core_pkg::GRP_CALL:
                        begin
                            stk_reg[sp_reg] <= pc_reg;
                            sp_reg          <= sp_inc;
                            pc_reg          <= nnn;
                        end
                        c8core_pkg::GRP_SE:
                        begin
                            pc_reg <= pc_reg + ((vx_reg == kk) ? 12'd4 : 12'd2);
                        end
                        c8core_pkg::GRP_SNE:
                        begin
                            pc_reg <= pc_reg + ((vx_reg != kk) ? 12'd4 : 12'd2);
                        end
                        c8core_pkg::GRP_SER:
                        begin
                            if (rn != 4'd0)
                            begin
                                st_reg <= 1'b1;
                            end
                            else
                            begin
                                pc_reg <= pc_reg + ((vx_reg == vy_reg) ? 12'd4 : 12'd2);
                            end
                        end
                        c8core_pkg::GRP_LD:
                        begin
                            v_reg[rx] <= kk;
                            pc_reg    <= pc_reg + 12'd2;
                        end
                        c8core_pkg::GRP_ADD:
                        begin
                            v_reg[rx] <= vx_reg + kk;
                            pc_reg    <= pc_reg + 12'd2;
                        end
                        c8core_pkg::GRP_LDI:
                        begin
                            idx_reg <= nnn;
                            pc_reg  <= pc_reg + 12'd2;
                        end
                        c8core_pkg::GRP_DRW:
                        begin
                            v_reg[c8core_pkg::FLAG_REG] <= 8'h00;
                            hit_reg <= 1'b0;
                            row_reg <= '0;
                            chg_reg <= 1'b1;
                            pc_reg  <= pc_reg + 12'd2;
                        end
                        default:
                        begin
                            st_reg <= 1'b1;
                        end
                    endcase
                end
                c8core_pkg::OP_DRAW_WRA:
                begin
                    hit_reg <= hit_reg | (|(fba_reg & mask_ab[15:8]));
                end
                c8core_pkg::OP_DRAW_WRB:
                begin
                    hit_reg <= hit_fin;
                    row_reg <= row_reg + 4'd1;
                    if (stat.draw_last)
                    begin
                        v_reg[c8core_pkg::FLAG_REG] <= {7'd0, hit_fin};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

/* sv/chip8_subset_cpu_core.sv */
// Channel   Dir  Payload
// request   in   command, address, load_byte
// result    out  pixel_byte, program_counter, executed_opcode, status, screen_changed
//
// One request at a time. Unknown commands go to finish; load and framebuffer read
// add their access; execute fetches both opcode bytes, reads Vx, Vy and executes;
// draw adds a sprite read, two framebuffer reads and two writes per sprite row.
// After reset a clearing pass writes the font and zeros to all MEMORY_BYTES bytes
// (4096 by default) with request.ready low. The result register frees the
// core while a result waits; a held result stalls only the next completion.
module chip8_subset_cpu_core #(
    parameter int MEMORY_BYTES = c8core_pkg::MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = c8core_pkg::STACK_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    c8core_req_if.sink   request,
    c8core_res_if.source result
);

    c8core_pkg::dp_op_t   op;
    c8core_pkg::dp_stat_t stat;

    c8core_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    c8core_dp #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .STACK_DEPTH  (STACK_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (op),
        .stat    (stat),
        .request (request),
        .result  (result)
    );

endmodule
